### src/suart_pkg.sv
`default_nettype none

package suart_pkg;

	// Bus access direction
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Register map: reads use the lower half, writes the upper half
	localparam logic [2:0] ADDR_RX_DATA = 3'd0;
	localparam logic [2:0] ADDR_STATUS  = 3'd1;
	localparam logic [2:0] ADDR_MODE_RD = 3'd2;
	localparam logic [2:0] ADDR_CMD_RD  = 3'd3;
	localparam logic [2:0] ADDR_TX_DATA = 3'd4;
	localparam logic [2:0] ADDR_SYNC_WR = 3'd5;
	localparam logic [2:0] ADDR_MODE_WR = 3'd6;
	localparam logic [2:0] ADDR_CMD_WR  = 3'd7;

	// Sync character slots
	localparam logic [1:0] SYNC_SYN1 = 2'd0;
	localparam logic [1:0] SYNC_SYN2 = 2'd1;
	localparam logic [1:0] SYNC_DLE  = 2'd2;
	localparam int         SYNC_NUM  = 3;

	// Stream word widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	// One bus access
	typedef struct packed {
		logic       req_type;
		logic [2:0] reg_addr;
		logic [7:0] write_data;
		logic       rx_available;
		logic [7:0] rx_byte;
		logic       tx_space;
	} suart_req_t;

	// Result of one bus access
	typedef struct packed {
		logic [7:0] read_data;
		logic       rx_pop;
		logic       tx_push;
		logic [7:0] tx_byte;
	} suart_rsp_t;

endpackage

`default_nettype wire

### src/suart_regs.sv
`default_nettype none

module suart_regs
	import suart_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire suart_req_t req,
	output suart_rsp_t      rsp
);

	logic [7:0] mode_one_q;
	logic [7:0] mode_two_q;
	logic [7:0] command_q;
	logic [7:0] sync_chars_q [SYNC_NUM];
	logic       mode_rd_ptr_q;
	logic       mode_wr_ptr_q;
	logic [1:0] sync_wr_ptr_q;
	logic       overrun_q;

	logic rd_ok;
	logic wr_ok;
	logic [7:0] status;

	assign rd_ok = (req.req_type == REQ_READ) && !req.reg_addr[2];
	assign wr_ok = (req.req_type == REQ_WRITE) && req.reg_addr[2];

	// Status: DSR, DCD, FE, overrun, PE, TxEMT, RxRDY, TxRDY
	assign status = {1'b1, 1'b1, 1'b0, overrun_q, 1'b0,
		req.tx_space, req.rx_available, req.tx_space};

	// Result word
	always_comb begin
		rsp = '0;
		if (rd_ok) begin
			case (req.reg_addr)
				ADDR_RX_DATA: begin
					if (req.rx_available) begin
						rsp.read_data = req.rx_byte;
						rsp.rx_pop    = 1'b1;
					end
				end
				ADDR_STATUS:  rsp.read_data = status;
				ADDR_MODE_RD: rsp.read_data = mode_rd_ptr_q ? mode_two_q : mode_one_q;
				ADDR_CMD_RD:  rsp.read_data = command_q;
				default:      rsp.read_data = '0;
			endcase
		end else if (wr_ok && req.reg_addr == ADDR_TX_DATA && req.tx_space) begin
			rsp.tx_push = 1'b1;
			rsp.tx_byte = req.write_data;
		end
	end

	// Register file and pointer updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_one_q    <= '0;
			mode_two_q    <= '0;
			command_q     <= '0;
			mode_rd_ptr_q <= 1'b0;
			mode_wr_ptr_q <= 1'b0;
			sync_wr_ptr_q <= SYNC_SYN1;
			overrun_q     <= 1'b0;
			for (int i = 0; i < SYNC_NUM; i++) begin
				sync_chars_q[i] <= '0;
			end
		end else if (en) begin
			if (rd_ok) begin
				case (req.reg_addr)
					ADDR_MODE_RD: mode_rd_ptr_q <= ~mode_rd_ptr_q;
					ADDR_CMD_RD: begin
						mode_rd_ptr_q <= 1'b0;
						mode_wr_ptr_q <= 1'b0;
						sync_wr_ptr_q <= SYNC_SYN1;
					end
					default: ;
				endcase
			end else if (wr_ok) begin
				case (req.reg_addr)
					ADDR_TX_DATA: begin
						if (!req.tx_space) overrun_q <= 1'b1;
					end
					ADDR_SYNC_WR: begin
						// an out-of-range slot loads nothing and wraps
						case (sync_wr_ptr_q)
							SYNC_SYN1: begin
								sync_chars_q[0] <= req.write_data;
								sync_wr_ptr_q   <= SYNC_SYN2;
							end
							SYNC_SYN2: begin
								sync_chars_q[1] <= req.write_data;
								sync_wr_ptr_q   <= SYNC_DLE;
							end
							SYNC_DLE: begin
								sync_chars_q[2] <= req.write_data;
								sync_wr_ptr_q   <= SYNC_SYN1;
							end
							default: sync_wr_ptr_q <= SYNC_SYN1;
						endcase
					end
					ADDR_MODE_WR: begin
						if (mode_wr_ptr_q) mode_two_q <= req.write_data;
						else               mode_one_q <= req.write_data;
						mode_wr_ptr_q <= ~mode_wr_ptr_q;
					end
					ADDR_CMD_WR: command_q <= req.write_data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### src/sync_async_uart_register_port_top.sv
`default_nettype none

// Register interface of a 2651-style UART. Each input word is one bus access
// (direction in tuser, address, write byte and the receive/transmit queue
// status in tdata) and gives exactly one result word: the read byte, a
// receive pop strobe and a transmit push with its byte. One access is taken
// every cycle while the result side is not stalled; an access passes through an
// input register and then a result register, around a single read-modify-write
// of the mode, command and sync registers. A stalled result holds the input
// register, and input is refused only while both registers are full.
module sync_async_uart_register_port_top
	import suart_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// [2:0] reg_addr, [10:3] write_data, [11] rx_available,
	// [19:12] rx_byte, [20] tx_space, [23:21] zero
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  wire logic                   s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [7:0] read_data, [8] rx_pop, [9] tx_push, [17:10] tx_byte, [23:18] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic       valid_s1;
	suart_req_t req_s1;
	logic       out_valid_q;
	suart_rsp_t rsp;
	suart_rsp_t rsp_q;
	logic       advance;
	logic       take_in;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1.req_type     <= s_axis_tuser;
			req_s1.reg_addr     <= s_axis_tdata[2:0];
			req_s1.write_data   <= s_axis_tdata[10:3];
			req_s1.rx_available <= s_axis_tdata[11];
			req_s1.rx_byte      <= s_axis_tdata[19:12];
			req_s1.tx_space     <= s_axis_tdata[20];
		end
	end

	suart_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.req    (req_s1),
		.rsp    (rsp)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= rsp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'd0, rsp_q.tx_byte, rsp_q.tx_push, rsp_q.rx_pop,
		rsp_q.read_data};

	// Input is refused only with both stages full and the output stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input refused with room in the pipeline");

	// An access in the input stage moves to the output when not stalled
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> out_valid_q)
		else $error("access lost between stages");

	// A result never both pops and pushes
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(rsp_q.rx_pop && rsp_q.tx_push))
		else $error("pop and push in one result");

	// No transmit byte without a push, no read byte alongside a push
	a_push_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (rsp_q.tx_push || rsp_q.tx_byte == 8'd0) &&
			(!rsp_q.tx_push || rsp_q.read_data == 8'd0))
		else $error("stray byte in result");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import suart_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [2:0] reg_addr, [10:3] write_data, [11] rx_available,
	// [19:12] rx_byte, [20] tx_space, [23:21] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// [0] req_type
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [7:0] read_data, [8] rx_pop, [9] tx_push, [17:10] tx_byte, [23:18] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	sync_async_uart_register_port_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Bus accesses waiting to be sent, and the result words they should give
	suart_req_t bus_access_q [$];
	suart_rsp_t uart_result_q [$];
	suart_req_t cur_access;

	// Our own copy of the UART register state
	logic [7:0] mode_reg [2];
	logic [7:0] cmd_reg;
	logic [7:0] sync_reg [SYNC_NUM];
	logic       mode_rd_sel;
	logic       mode_wr_sel;
	logic [1:0] sync_sel;
	logic       overrun;

	int fail_count = 0;
	int results_seen = 0;
	int burst_left = 1;
	int gap_left = 0;
	int cyc_count = 0;
	int hold_left = 0;
	int holds_done = 0;

	// Clock
	initial begin
		forever #6 clk = ~clk;
	end

	// Apply one bus access to the register state and work out its result word
	function automatic suart_rsp_t uart_register_access(suart_req_t acc);
		suart_rsp_t rsp;
		rsp = '0;
		if (acc.req_type == REQ_READ) begin
			case (acc.reg_addr)
				ADDR_RX_DATA: begin
					if (acc.rx_available) begin
						rsp.read_data = acc.rx_byte;
						rsp.rx_pop = 1'b1;
					end
				end
				// DSR, DCD, framing, overrun, parity, TxEMT, RxRDY, TxRDY
				ADDR_STATUS: rsp.read_data = {2'b11, 1'b0, overrun, 1'b0,
					acc.tx_space, acc.rx_available, acc.tx_space};
				ADDR_MODE_RD: begin
					rsp.read_data = mode_reg[mode_rd_sel];
					mode_rd_sel = ~mode_rd_sel;
				end
				ADDR_CMD_RD: begin
					rsp.read_data = cmd_reg;
					mode_rd_sel = 1'b0;
					mode_wr_sel = 1'b0;
					sync_sel = SYNC_SYN1;
				end
				default: ;
			endcase
		end else begin
			case (acc.reg_addr)
				ADDR_TX_DATA: begin
					if (acc.tx_space) begin
						rsp.tx_push = 1'b1;
						rsp.tx_byte = acc.write_data;
					end else begin
						overrun = 1'b1;
					end
				end
				ADDR_SYNC_WR: begin
					// a pointer beyond DLE loads nothing and wraps
					if (sync_sel <= SYNC_DLE)
						sync_reg[sync_sel] = acc.write_data;
					sync_sel = (sync_sel >= SYNC_DLE) ? SYNC_SYN1 : sync_sel + 2'd1;
				end
				ADDR_MODE_WR: begin
					mode_reg[mode_wr_sel] = acc.write_data;
					mode_wr_sel = ~mode_wr_sel;
				end
				ADDR_CMD_WR: cmd_reg = acc.write_data;
				default: ;
			endcase
		end
		return rsp;
	endfunction

	function automatic suart_req_t bus_access(logic rw, logic [2:0] addr, logic [7:0] wd,
			logic rx_av, logic [7:0] rx_b, logic tx_sp);
		suart_req_t acc;
		acc.req_type = rw;
		acc.reg_addr = addr;
		acc.write_data = wd;
		acc.rx_available = rx_av;
		acc.rx_byte = rx_b;
		acc.tx_space = tx_sp;
		return acc;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Sender: bursts of words with random gaps; predicts on each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				uart_result_q.push_back(uart_register_access(cur_access));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (bus_access_q.size() > 0) begin
					cur_access = bus_access_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {3'b000, cur_access.tx_space, cur_access.rx_byte,
						cur_access.rx_available, cur_access.write_data, cur_access.reg_addr};
					s_axis_tuser <= cur_access.req_type;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: rotating stall pattern, plus two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			cyc_count++;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (holds_done < 2 && results_seen >= 400 + holds_done * 700) begin
				hold_left = 150;
				holds_done++;
				m_axis_tready <= 1'b0;
			end else begin
				case ((cyc_count / 64) % 4)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					2: m_axis_tready <= (cyc_count % 3 == 0);
					default: m_axis_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Result check against the oldest outstanding prediction
	always @(posedge clk) begin
		suart_rsp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (uart_result_q.size() == 0) begin
				$error("result word 0x%0h with no access outstanding", m_axis_tdata);
				fail_count++;
			end else begin
				want = uart_result_q.pop_front();
				check_field("read_data", want.read_data, m_axis_tdata[7:0]);
				check_field("rx_pop", want.rx_pop, m_axis_tdata[8]);
				check_field("tx_push", want.tx_push, m_axis_tdata[9]);
				check_field("tx_byte", want.tx_byte, m_axis_tdata[17:10]);
				check_field("pad", 0, m_axis_tdata[23:18]);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		suart_req_t acc;
		int formed;

		mode_reg[0] = '0;
		mode_reg[1] = '0;
		cmd_reg = '0;
		for (int i = 0; i < SYNC_NUM; i++)
			sync_reg[i] = '0;
		mode_rd_sel = 1'b0;
		mode_wr_sel = 1'b0;
		sync_sel = SYNC_SYN1;
		overrun = 1'b0;

		// directed: reset values, status, empty receive, mode and sync rotation
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_MODE_RD, 8'h00, 1'b0, 8'h00, 1'b0));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_CMD_RD, 8'hFF, 1'b1, 8'hFF, 1'b1));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_STATUS, 8'h00, 1'b0, 8'h00, 1'b0));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_STATUS, 8'hFF, 1'b1, 8'hFF, 1'b1));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_RX_DATA, 8'h00, 1'b0, 8'hFF, 1'b1));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_RX_DATA, 8'h00, 1'b1, 8'hFF, 1'b0));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_MODE_WR, 8'hA5, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_MODE_WR, 8'h5A, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_MODE_WR, 8'hFF, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_MODE_RD, 8'h00, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_MODE_RD, 8'h00, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_CMD_WR, 8'hFF, 1'b0, 8'h00, 1'b1));
		// command read pulls every pointer back to the start
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_CMD_RD, 8'h00, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_MODE_WR, 8'h22, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_MODE_RD, 8'h00, 1'b0, 8'h00, 1'b1));
		for (int i = 0; i < 4; i++)
			bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_SYNC_WR, 8'(8'h10 + i), 1'b0,
				8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_TX_DATA, 8'hFF, 1'b0, 8'h00, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_TX_DATA, 8'h00, 1'b1, 8'hFF, 1'b1));
		// transmit write with no room: sticky overrun, seen in status
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_TX_DATA, 8'h3C, 1'b0, 8'h00, 1'b0));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_STATUS, 8'h00, 1'b0, 8'h00, 1'b1));
		// wrong direction for the address
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_TX_DATA, $urandom, 1'b1, $urandom, 1'b1));
		bus_access_q.push_back(bus_access(REQ_READ, ADDR_CMD_WR, $urandom, 1'b1, $urandom, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_RX_DATA, $urandom, 1'b1, $urandom, 1'b1));
		bus_access_q.push_back(bus_access(REQ_WRITE, ADDR_CMD_RD, $urandom, 1'b1, $urandom, 1'b0));

		// random: mostly well-formed accesses, some with the wrong direction
		formed = 0;
		while (formed < 1625) begin
			acc.req_type = $urandom_range(0, 1);
			if ($urandom_range(0, 99) < 12) begin
				acc.reg_addr = acc.req_type ? $urandom_range(0, 3) : $urandom_range(4, 7);
			end else begin
				acc.reg_addr = acc.req_type ? $urandom_range(4, 7) : $urandom_range(0, 3);
			end
			formed++;
			acc.write_data = $urandom;
			acc.rx_available = $urandom_range(0, 1);
			acc.rx_byte = $urandom;
			acc.tx_space = ($urandom_range(0, 3) != 0);
			bus_access_q.push_back(acc);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (bus_access_q.size() > 0 || s_axis_tvalid || uart_result_q.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
